FILE: hw/rtl/lrpw_pkg.sv
// shared types, constants and helpers of the rectangle pixel writer
package lrpw_pkg;

	localparam int CoordW = 16;
	localparam int SpanW = CoordW + 1;
	localparam int BudgetW = 23;
	localparam int ColourW = 24;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW = $clog2(QueueDepth);

	localparam logic [BudgetW-1:0] BudgetMax = '1;
	localparam logic [ColourW-1:0] FgReset = 24'hFF_FFFF;
	localparam logic [ColourW-1:0] BgReset = 24'h00_0000;

	// display command bytes
	localparam logic [7:0] CmdColumn = 8'h2A;
	localparam logic [7:0] CmdRow = 8'h2B;
	localparam logic [7:0] CmdWrite = 8'h2C;

	// byte positions of the command bytes within a region sequence
	localparam logic [3:0] StepColumn = 4'd0;
	localparam logic [3:0] StepRow = 4'd5;
	localparam logic [3:0] StepWrite = 4'd10;

	// configuration register indexes
	localparam logic CfgFg = 1'b0;
	localparam logic CfgBg = 1'b1;

	typedef enum logic [1:0] {
		OP_REGION = 2'd0,
		OP_MONO   = 2'd1,
		OP_RUN    = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_FILL  = 2'd1,
		KIND_MONO  = 2'd2,
		KIND_RUN   = 2'd3
	} kind_t;

	typedef struct packed {
		op_t                 op;
		kind_t               kind;
		logic [CoordW-1:0]   xs;
		logic [CoordW-1:0]   xe;
		logic [CoordW-1:0]   ys;
		logic [CoordW-1:0]   ye;
		logic [7:0]          mono_bits;
		logic [7:0]          run_length;
		logic [ColourW-1:0]  run_colour;
		logic [BudgetW-1:0]  budget;
	} item_t;

	typedef struct packed {
		logic [ColourW-1:0] fg;
		logic [ColourW-1:0] bg;
	} colours_t;

	// pixel bytes go out high byte first
	function automatic logic [7:0] colour_byte(input logic [ColourW-1:0] c,
			input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = c[23:16];
			2'd1: b = c[15:8];
			default: b = c[7:0];
		endcase
		return b;
	endfunction

endpackage

FILE: hw/rtl/lrpw_front.sv
// front end: takes request transactions, works out the pixel budget, feeds the queue
module lrpw_front import lrpw_pkg::*; #(
	parameter int COORD_BITS = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [1:0]            mode,
	input  logic [1:0]            paint_kind,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] y_end,
	input  logic [7:0]            mono_bits,
	input  logic [7:0]            run_length,
	input  logic [ColourW-1:0]    run_colour,
	output logic                  push,
	output item_t                 push_item,
	input  logic                  full
);

	logic                 valid_s1, valid_s2;
	item_t                item_s1, item_s2;
	logic [SpanW-1:0]     span_x_s1, span_y_s1;
	logic [COORD_BITS:0]  span_x, span_y;
	logic [2*SpanW-1:0]   product;
	logic [BudgetW-1:0]   budget;
	logic                 ready_s1, ready_s2;

	// inclusive span, zero when the end lies below the start
	assign span_x = (x_end < x_start) ? '0 :
		((COORD_BITS+1)'(x_end) - (COORD_BITS+1)'(x_start) + 1'b1);
	assign span_y = (y_end < y_start) ? '0 :
		((COORD_BITS+1)'(y_end) - (COORD_BITS+1)'(y_start) + 1'b1);

	assign product = span_x_s1 * span_y_s1;
	assign budget = (product > (2*SpanW)'(BudgetMax)) ? BudgetMax : product[BudgetW-1:0];

	assign ready_s2 = !valid_s2 || !full;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign req_stall = !ready_s1;

	assign push = valid_s2 && !full;
	assign push_item = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= req_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && req_valid) begin
			item_s1.op <= op_t'(mode);
			item_s1.kind <= kind_t'(paint_kind);
			item_s1.xs <= CoordW'(x_start);
			item_s1.xe <= CoordW'(x_end);
			item_s1.ys <= CoordW'(y_start);
			item_s1.ye <= CoordW'(y_end);
			item_s1.mono_bits <= mono_bits;
			item_s1.run_length <= run_length;
			item_s1.run_colour <= run_colour;
			item_s1.budget <= '0;
			span_x_s1 <= SpanW'(span_x);
			span_y_s1 <= SpanW'(span_y);
		end
		// budget is the lowest field of the item
		if (ready_s2 && valid_s1) begin
			item_s2 <= item_t'({item_s1[$bits(item_t)-1:BudgetW], budget});
		end
	end

endmodule

FILE: hw/rtl/lrpw_queue.sv
// short item queue between front and back end
module lrpw_queue import lrpw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t head,
	output logic  empty
);

	item_t                entry_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QueuePtrW:0]   count_q;

	assign full = (count_q == (QueuePtrW+1)'(QueueDepth));
	assign empty = (count_q == '0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_item;
	end

endmodule

FILE: hw/rtl/lrpw_back.sv
// back end: holds the paint state and sends bytes through the output register
module lrpw_back import lrpw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  colours_t colours,
	input  item_t    head,
	input  logic     empty,
	output logic     pop,
	output logic     bus_valid,
	input  logic     bus_stall,
	output logic     is_data,
	output logic [7:0] bus_byte,
	output logic     last_of_item,
	output logic     window_done
);

	// item in progress
	logic               work_valid_q;
	item_t              work_q;
	logic [3:0]         step_q;
	logic [1:0]         sub_q;
	logic [7:0]         bits_q;

	// paint state
	logic [BudgetW-1:0] pixels_left_q;
	logic [7:0]         run_left_q;
	logic [ColourW-1:0] run_colour_q;
	kind_t              kind_q;

	// output register
	logic               out_valid_q;
	logic               is_data_q, last_q, done_q;
	logic [7:0]         byte_q;

	logic               load_ok, emit, finish, proceed, px_end, active;
	logic               d_is_data, d_last, d_done;
	logic [7:0]         d_byte;
	logic [ColourW-1:0] colour;

	assign load_ok = !out_valid_q || !bus_stall;
	assign px_end = (sub_q == 2'd2);

	always_comb begin
		emit = 1'b0;
		finish = 1'b1;
		active = 1'b0;
		d_is_data = 1'b1;
		d_byte = '0;
		d_last = 1'b0;
		d_done = 1'b0;
		colour = colours.bg;
		case (work_q.op)
			OP_REGION: begin
				emit = 1'b1;
				finish = (step_q == StepWrite);
				d_last = finish;
				case (step_q)
					StepColumn: begin
						d_is_data = 1'b0;
						d_byte = CmdColumn;
					end
					4'd1: d_byte = work_q.xs[15:8];
					4'd2: d_byte = work_q.xs[7:0];
					4'd3: d_byte = work_q.xe[15:8];
					4'd4: d_byte = work_q.xe[7:0];
					StepRow: begin
						d_is_data = 1'b0;
						d_byte = CmdRow;
					end
					4'd6: d_byte = work_q.ys[15:8];
					4'd7: d_byte = work_q.ys[7:0];
					4'd8: d_byte = work_q.ye[15:8];
					4'd9: d_byte = work_q.ye[7:0];
					StepWrite: begin
						d_is_data = 1'b0;
						d_byte = CmdWrite;
					end
					default: d_byte = '0;
				endcase
			end
			OP_MONO: begin
				active = (kind_q == KIND_MONO) && (pixels_left_q != '0);
				colour = bits_q[7] ? colours.fg : colours.bg;
				emit = active;
				d_byte = colour_byte(colour, sub_q);
				// item ends on its eighth pixel or when the budget runs out
				d_last = px_end && ((step_q == 4'd7) || (pixels_left_q == BudgetW'(1)));
				d_done = px_end && (pixels_left_q == BudgetW'(1));
				finish = !active || d_last;
			end
			OP_RUN: begin
				finish = 1'b1;
			end
			OP_TICK: begin
				active = (pixels_left_q != '0) && ((kind_q == KIND_FILL) ||
					((kind_q == KIND_RUN) && (run_left_q != '0)));
				colour = (kind_q == KIND_FILL) ? colours.bg : run_colour_q;
				emit = active;
				d_byte = colour_byte(colour, sub_q);
				d_last = px_end;
				d_done = px_end && (pixels_left_q == BudgetW'(1));
				finish = !active || px_end;
			end
			default: finish = 1'b1;
		endcase
	end

	assign proceed = work_valid_q && (!emit || load_ok);
	assign pop = !empty && (!work_valid_q || (proceed && finish));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
			step_q <= '0;
			sub_q <= '0;
			pixels_left_q <= '0;
			run_left_q <= '0;
			run_colour_q <= '0;
			kind_q <= KIND_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (load_ok) out_valid_q <= work_valid_q && emit;

			if (pop) begin
				work_valid_q <= 1'b1;
				step_q <= '0;
				sub_q <= '0;
			end else if (proceed && finish) begin
				work_valid_q <= 1'b0;
			end else if (proceed) begin
				if (work_q.op == OP_REGION || px_end) begin
					step_q <= step_q + 1'b1;
					sub_q <= '0;
				end else begin
					sub_q <= sub_q + 1'b1;
				end
			end

			if (proceed) begin
				case (work_q.op)
					OP_REGION: begin
						if (finish) begin
							kind_q <= work_q.kind;
							run_left_q <= '0;
							pixels_left_q <= (work_q.kind == KIND_CLEAR) ? '0 : work_q.budget;
						end
					end
					OP_MONO: begin
						if (active && px_end) pixels_left_q <= pixels_left_q - 1'b1;
					end
					OP_RUN: begin
						if (kind_q == KIND_RUN) begin
							run_left_q <= work_q.run_length;
							run_colour_q <= work_q.run_colour;
						end
					end
					OP_TICK: begin
						if (active && px_end) begin
							pixels_left_q <= pixels_left_q - 1'b1;
							// a run that reaches the end of the window is dropped
							if (kind_q == KIND_RUN)
								run_left_q <= (pixels_left_q == BudgetW'(1)) ? '0 :
									run_left_q - 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= head;
			bits_q <= head.mono_bits;
		end else if (proceed && !finish && work_q.op == OP_MONO && px_end) begin
			bits_q <= {bits_q[6:0], 1'b0};
		end
		if (load_ok && work_valid_q && emit) begin
			is_data_q <= d_is_data;
			byte_q <= d_byte;
			last_q <= d_last;
			done_q <= d_done;
		end
	end

	assign bus_valid = out_valid_q;
	assign is_data = is_data_q;
	assign bus_byte = byte_q;
	assign last_of_item = last_q;
	assign window_done = done_q;

`ifndef SYNTHESIS
	a_done_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> last_q && is_data_q)
		else $error("window completion not on the last data byte of a transaction");

	a_clear_no_budget: assert property (@(posedge clk) disable iff (!arst_n)
		proceed && finish && work_q.op == OP_REGION && work_q.kind == KIND_CLEAR
		|=> pixels_left_q == '0)
		else $error("clear window left a pixel budget");

	a_region_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		work_valid_q && work_q.op == OP_REGION |-> step_q <= StepWrite)
		else $error("region sequence ran past the memory write command");

	a_pixel_needs_budget: assert property (@(posedge clk) disable iff (!arst_n)
		proceed && active && px_end |=> pixels_left_q == $past(pixels_left_q) - 1'b1)
		else $error("pixel sent without taking one from the budget");
`endif

endmodule

FILE: hw/rtl/lcd_rectangle_pixel_writer.sv
// top level of the rectangle pixel writer for an 8-bit display bus
// Turns paint request transactions into command and data bytes for an 8-bit display
// bus. A region transaction sends column set, row set and memory write (11 bytes)
// and loads the pixel budget; each pixel is three data bytes, high byte first. The
// output byte register moves one byte per cycle while the bus does not stall. A
// tick sends at most one pixel, a mono byte at most eight, and a run word or a
// transaction that sends nothing puts no byte on the bus. Requests pass a two-stage
// front end (span, then budget multiply) and a four-entry queue, so requests keep
// being taken while the bus side is stalled until the queue fills. Colour registers
// are read while pixels go out, so write them only while the block is idle.
module lcd_rectangle_pixel_writer import lrpw_pkg::*; #(
	parameter int COORD_BITS = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [ColourW-1:0]    cfg_data,
	// request channel
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [1:0]            mode,
	input  logic [1:0]            paint_kind,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] y_end,
	input  logic [7:0]            mono_bits,
	input  logic [7:0]            run_length,
	input  logic [ColourW-1:0]    run_colour,
	// display bus channel
	output logic                  bus_valid,
	input  logic                  bus_stall,
	output logic                  is_data,
	output logic [7:0]            bus_byte,
	output logic                  last_of_item,
	output logic                  window_done
);

	colours_t colours_q;
	logic     push, full, pop, empty;
	item_t    push_item, head;

	// foreground and background colour registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colours_q.fg <= FgReset;
			colours_q.bg <= BgReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgFg: colours_q.fg <= cfg_data;
				CfgBg: colours_q.bg <= cfg_data;
				default: ;
			endcase
		end
	end

	// front end: budget computed before the item enters the queue
	lrpw_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.mode       (mode),
		.paint_kind (paint_kind),
		.x_start    (x_start),
		.x_end      (x_end),
		.y_start    (y_start),
		.y_end      (y_end),
		.mono_bits  (mono_bits),
		.run_length (run_length),
		.run_colour (run_colour),
		.push       (push),
		.push_item  (push_item),
		.full       (full)
	);

	// decouples request intake from bus pacing
	lrpw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// back end: paint state and byte sequencing
	lrpw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.colours      (colours_q),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.bus_valid    (bus_valid),
		.bus_stall    (bus_stall),
		.is_data      (is_data),
		.bus_byte     (bus_byte),
		.last_of_item (last_of_item),
		.window_done  (window_done)
	);

endmodule

FILE: bench/lcd_rectangle_pixel_writer_tb.sv
// self-checking bench for the rectangle pixel writer, paint transactions against a byte predictor
module lcd_rectangle_pixel_writer_tb;
	import lrpw_pkg::*;

	localparam int COORD_W = 11;
	// no-progress limit, far above the worst gap, stall and drain
	localparam int WATCHDOG_LIMIT = 4000;
	// front end stages plus a full queue of silent transactions
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS = 10;

	// one paint request as it sits on the request channel
	typedef struct {
		op_t                op;
		kind_t              kind;
		logic [COORD_W-1:0] xs;
		logic [COORD_W-1:0] xe;
		logic [COORD_W-1:0] ys;
		logic [COORD_W-1:0] ye;
		logic [7:0]         mono;
		logic [7:0]         run_len;
		logic [ColourW-1:0] run_rgb;
	} paint_req_t;

	// one byte on the display bus
	typedef struct {
		logic       is_data;
		logic [7:0] value;
		logic       last;
		logic       done;
	} bus_word_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_style_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic                  cfg_index = CfgFg;
	logic [ColourW-1:0]    cfg_data = '0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	logic [1:0]            mode = OP_TICK;
	logic [1:0]            paint_kind = KIND_CLEAR;
	logic [COORD_W-1:0]    x_start = '0;
	logic [COORD_W-1:0]    x_end = '0;
	logic [COORD_W-1:0]    y_start = '0;
	logic [COORD_W-1:0]    y_end = '0;
	logic [7:0]            mono_bits = '0;
	logic [7:0]            run_length = '0;
	logic [ColourW-1:0]    run_colour = '0;
	logic                  bus_valid;
	logic                  bus_stall = 1'b0;
	logic                  is_data;
	logic [7:0]            bus_byte;
	logic                  last_of_item;
	logic                  window_done;

	lcd_rectangle_pixel_writer #(.COORD_BITS(COORD_W)) dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// requests waiting for the driver, bytes waiting for the bus
	paint_req_t paint_reqs[$];
	bus_word_t  bytes_due[$];
	bus_word_t  item_words[$];

	// predictor state, mirrors the block's registers
	logic [BudgetW-1:0] budget_left = '0;
	logic [7:0]         run_pixels = '0;
	logic [ColourW-1:0] run_rgb = '0;
	kind_t              cur_kind = KIND_CLEAR;
	logic [ColourW-1:0] fg_rgb = FgReset;
	logic [ColourW-1:0] bg_rgb = BgReset;

	int mismatches = 0;
	int bytes_seen = 0;
	int quiet_cycles = 0;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	function automatic void emit(logic d, logic [7:0] b, logic dn);
		item_words.push_back('{is_data: d, value: b, last: 1'b0, done: dn});
	endfunction

	// coordinates go out as two data bytes, high first
	function automatic void emit_coord(logic [COORD_W-1:0] c);
		logic [15:0] wide;
		wide = 16'(c);
		emit(1'b1, wide[15:8], 1'b0);
		emit(1'b1, wide[7:0], 1'b0);
	endfunction

	// one pixel, only while the budget lasts; done flag on its third byte
	function automatic void emit_pixel(logic [ColourW-1:0] c);
		if (budget_left != 0) begin
			budget_left--;
			emit(1'b1, c[23:16], 1'b0);
			emit(1'b1, c[15:8], 1'b0);
			emit(1'b1, c[7:0], budget_left == 0);
		end
	endfunction

	function automatic void predict_bus_bytes(paint_req_t r);
		logic [11:0] span_x;
		logic [11:0] span_y;
		logic [23:0] area;
		logic [7:0]  bits;
		item_words.delete();
		case (r.op)
			OP_REGION: begin
				emit(1'b0, CmdColumn, 1'b0);
				emit_coord(r.xs);
				emit_coord(r.xe);
				emit(1'b0, CmdRow, 1'b0);
				emit_coord(r.ys);
				emit_coord(r.ye);
				emit(1'b0, CmdWrite, 1'b0);
				// an end below its start gives an empty window
				span_x = (r.xe < r.xs) ? 12'd0 : 12'(r.xe) - 12'(r.xs) + 12'd1;
				span_y = (r.ye < r.ys) ? 12'd0 : 12'(r.ye) - 12'(r.ys) + 12'd1;
				area = 24'(span_x) * 24'(span_y);
				cur_kind = r.kind;
				run_pixels = '0;
				if (r.kind == KIND_CLEAR)
					budget_left = '0;
				else if (area > 24'(BudgetMax))
					budget_left = BudgetMax;
				else
					budget_left = area[BudgetW-1:0];
			end
			OP_MONO: begin
				// msb first, set bits take the foreground
				if (cur_kind == KIND_MONO) begin
					bits = r.mono;
					for (int i = 0; i < 8; i++) begin
						emit_pixel(bits[7] ? fg_rgb : bg_rgb);
						bits = {bits[6:0], 1'b0};
					end
				end
			end
			OP_RUN: begin
				// a new run word replaces whatever run is pending
				if (cur_kind == KIND_RUN) begin
					run_pixels = r.run_len;
					run_rgb = r.run_rgb;
				end
			end
			default: begin
				if (cur_kind == KIND_FILL)
					emit_pixel(bg_rgb);
				else if (cur_kind == KIND_RUN && run_pixels != 0 && budget_left != 0) begin
					emit_pixel(run_rgb);
					run_pixels--;
					// the budget clips the run
					if (budget_left == 0)
						run_pixels = '0;
				end
			end
		endcase
		if (item_words.size() != 0)
			item_words[item_words.size() - 1].last = 1'b1;
		foreach (item_words[i])
			bytes_due.push_back(item_words[i]);
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers, every field not in use is random
	// ------------------------------------------------------------------

	function automatic paint_req_t random_req(op_t op);
		paint_req_t r;
		r.op = op;
		r.kind = kind_t'(2'($urandom));
		r.xs = COORD_W'($urandom);
		r.xe = COORD_W'($urandom);
		r.ys = COORD_W'($urandom);
		r.ye = COORD_W'($urandom);
		r.mono = 8'($urandom);
		r.run_len = 8'($urandom);
		r.run_rgb = 24'($urandom);
		return r;
	endfunction

	function automatic void add_region(kind_t k, logic [COORD_W-1:0] xs, xe, ys, ye);
		paint_req_t r;
		r = random_req(OP_REGION);
		r.kind = k;
		r.xs = xs;
		r.xe = xe;
		r.ys = ys;
		r.ye = ye;
		paint_reqs.push_back(r);
	endfunction

	function automatic void add_op(op_t op);
		paint_reqs.push_back(random_req(op));
	endfunction

	function automatic void add_mono(logic [7:0] bits);
		paint_reqs.push_back(random_req(OP_MONO));
		paint_reqs[paint_reqs.size() - 1].mono = bits;
	endfunction

	function automatic void add_run(logic [7:0] len, logic [ColourW-1:0] rgb);
		paint_reqs.push_back(random_req(OP_RUN));
		paint_reqs[paint_reqs.size() - 1].run_len = len;
		paint_reqs[paint_reqs.size() - 1].run_rgb = rgb;
	endfunction

	// a region and a body that suits its kind, with some noise mixed in;
	// returns the number of transactions that do something
	function automatic int add_paint_sequence();
		paint_req_t r;
		int useful;
		int body;
		r = random_req(OP_REGION);
		case ($urandom_range(0, 9))
			8: ;
			9: begin
				// end below start on one axis or both
				r.xe = r.xs - COORD_W'($urandom_range(1, 4));
				r.ye = r.ys + COORD_W'($urandom_range(0, 3));
				if ($urandom_range(0, 1) == 0)
					r.ye = r.ys - COORD_W'($urandom_range(1, 4));
			end
			default: begin
				// mostly small windows so the budget runs out often
				r.xe = r.xs + COORD_W'($urandom_range(0, 5));
				r.ye = r.ys + COORD_W'($urandom_range(0, 3));
			end
		endcase
		paint_reqs.push_back(r);
		useful = 1;
		body = $urandom_range(1, 10);
		for (int i = 0; i < body; i++) begin
			if (r.kind == KIND_CLEAR || $urandom_range(0, 9) == 0)
				add_op(op_t'(2'($urandom_range(1, 3))));
			else begin
				useful++;
				case (r.kind)
					KIND_FILL: add_op(OP_TICK);
					KIND_MONO: add_mono(8'($urandom));
					default: begin
						if (i == 0 || $urandom_range(0, 2) == 0)
							add_run(($urandom_range(0, 4) == 0) ? 8'($urandom)
								: 8'($urandom_range(1, 6)), 24'($urandom));
						else
							add_op(OP_TICK);
					end
				endcase
			end
		end
		return useful;
	endfunction

	// ------------------------------------------------------------------
	// request driver: bursts of random length with random gaps
	// ------------------------------------------------------------------

	paint_req_t on_bus;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin : drive_requests
		logic taken;
		taken = req_valid && !req_stall;
		// predict at acceptance, colours are stable between phases
		if (taken) begin
			predict_bus_bytes(on_bus);
			if (burst_left != 0)
				burst_left--;
		end
		// payload only moves once the current transaction is taken
		if (arst_n && (!req_valid || taken)) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			end
			if (gap_left != 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (paint_reqs.size() != 0) begin
				on_bus = paint_reqs.pop_front();
				req_valid <= 1'b1;
				mode <= on_bus.op;
				paint_kind <= on_bus.kind;
				x_start <= on_bus.xs;
				x_end <= on_bus.xe;
				y_start <= on_bus.ys;
				y_end <= on_bus.ye;
				mono_bits <= on_bus.mono;
				run_length <= on_bus.run_len;
				run_colour <= on_bus.run_rgb;
			end else
				req_valid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// bus monitor, stall pattern and watchdog
	// ------------------------------------------------------------------

	stall_style_t stall_style = STALL_NONE;
	int style_left = 0;
	int stall_period = 2;
	int stall_phase = 0;

	always @(posedge clk) begin : watch_bus
		bus_word_t want;
		logic got;
		logic hold;
		if (arst_n) begin
			got = bus_valid && !bus_stall;
			if (got) begin
				bytes_seen++;
				if (bytes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("bus byte %0d with nothing pending: data=%b byte=%h last=%b done=%b",
							bytes_seen, is_data, bus_byte, last_of_item, window_done);
				end else begin
					want = bytes_due.pop_front();
					if (want.is_data !== is_data || want.value !== bus_byte
							|| want.last !== last_of_item || want.done !== window_done) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("bus byte %0d: expected data=%b byte=%h last=%b done=%b, got data=%b byte=%h last=%b done=%b",
								bytes_seen, want.is_data, want.value, want.last, want.done,
								is_data, bus_byte, last_of_item, window_done);
					end
				end
			end

			// pick a new stall style now and then, including stretches with none
			if (style_left == 0) begin
				stall_style = stall_style_t'(2'($urandom));
				style_left = $urandom_range(20, 80);
				stall_period = $urandom_range(2, 4);
			end
			style_left--;
			stall_phase++;
			case (stall_style)
				STALL_NONE: hold = 1'b0;
				STALL_LIGHT: hold = ($urandom_range(0, 3) == 0);
				STALL_HEAVY: hold = ($urandom_range(0, 3) != 0);
				default: hold = (stall_phase % stall_period) != 0;
			endcase
			bus_stall <= hold;

			// watchdog on cycles with no transaction on either side
			if (got || (req_valid && !req_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// phase control
	// ------------------------------------------------------------------

	// everything sent and every byte back, then let silent work finish
	task automatic wait_idle();
		do
			@(negedge clk);
		while (paint_reqs.size() != 0 || req_valid || bytes_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// colour registers only change while the block is idle
	task automatic write_colours(logic [ColourW-1:0] fg, logic [ColourW-1:0] bg);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CfgFg;
		cfg_data <= fg;
		@(posedge clk);
		cfg_index <= CfgBg;
		cfg_data <= bg;
		@(posedge clk);
		cfg_we <= 1'b0;
		fg_rgb = fg;
		bg_rgb = bg;
	endtask

	initial begin
		int useful;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed transactions with the reset colours
		add_mono(8'hFF);                                       // mono byte outside mono kind
		add_run(8'd5, 24'hFFFFFF);                             // run word outside run kind
		add_region(KIND_CLEAR, 11'd0, 11'd2047, 11'd2047, 11'd0);
		add_op(OP_TICK);                                       // tick in clear kind
		add_region(KIND_FILL, 11'd2047, 11'd2047, 11'd5, 11'd6);
		add_op(OP_TICK);
		add_op(OP_TICK);
		add_op(OP_TICK);                                       // budget already used up
		add_region(KIND_FILL, 11'd9, 11'd3, 11'd0, 11'd0);      // end below start
		add_op(OP_TICK);
		add_region(KIND_MONO, 11'd0, 11'd2, 11'd0, 11'd0);
		add_mono(8'hA5);                                       // bits past the budget dropped
		add_mono(8'hFF);                                       // zero budget, sends nothing
		add_region(KIND_MONO, 11'd100, 11'd103, 11'd7, 11'd9);
		add_mono(8'h00);
		add_mono(8'hFF);                                       // bits run on across rows
		add_region(KIND_RUN, 11'd1024, 11'd1028, 11'd1023, 11'd1023);
		add_op(OP_TICK);                                       // no run loaded yet
		add_run(8'd0, 24'h123456);
		add_run(8'd3, 24'hFFFFFF);
		add_op(OP_TICK);
		add_run(8'd255, 24'h000000);                           // replaces the pending run
		for (int i = 0; i < 4; i++)
			add_op(OP_TICK);                                   // last one clips the run
		add_mono(8'h81);                                       // mono byte in run kind
		add_region(KIND_RUN, 11'd0, 11'd2047, 11'd0, 11'd2047);
		add_run(8'd200, 24'hA5A5A5);
		add_op(OP_TICK);
		add_region(KIND_RUN, 11'd0, 11'd0, 11'd0, 11'd0);       // region drops the old run
		add_op(OP_TICK);

		useful = 0;
		while (useful < 25)
			useful += add_paint_sequence();
		wait_idle();

		// then the colour extremes swapped, then random colours
		for (int p = 0; p < 3; p++) begin
			if (p == 0)
				write_colours(24'h000000, 24'hFFFFFF);
			else
				write_colours(24'($urandom), 24'($urandom));
			useful = 0;
			while (useful < 45)
				useful += add_paint_sequence();
			wait_idle();
		end

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
